/* src/crsf_rx_pkg.sv */
package crsf_rx_pkg;

  localparam int FRAME_BYTES   = 64;
  localparam int STORE_AW      = $clog2(FRAME_BYTES);
  localparam int MAX_LENGTH    = FRAME_BYTES - 2;
  localparam int MIN_LENGTH    = 2;

  localparam logic [7:0]  CRC_POLY      = 8'hD5;
  localparam logic [7:0]  RC_TYPE       = 8'h16;
  localparam logic [7:0]  RC_LENGTH     = 8'd24;
  localparam logic [31:0] GAP_RESET     = 32'd2000;
  localparam logic [7:0]  ADDR_RESET    = 8'hC8;

  localparam int CHAN_W        = 11;
  localparam int NUM_CHANNELS  = 16;
  localparam int ACC_W         = CHAN_W + 7;
  localparam int ACC_CNT_W     = $clog2(ACC_W + 1);
  localparam logic [STORE_AW-1:0] PAYLOAD_FIRST = STORE_AW'(3);

  // configuration register indexes
  localparam logic REG_GAP_LIMIT      = 1'b0;
  localparam logic REG_DEVICE_ADDRESS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_LOAD = 4'b0100,
    S_EMIT = 4'b1000
  } unpack_state_t;

  // one byte through the crc-8, msb first
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

/* src/crsf_rx_ram.sv */
module crsf_rx_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/crsf_rc_frame_receiver.sv */
// Receives serial bytes on the in_ channel, one word per byte with its
// arrival timestamp in tdata and the line-error flag in tuser. Frames
// addressed to device_address are parsed as they arrive: the crc-8 runs
// byte by byte and every frame byte is written into a 64-entry frame store.
// A frame with a good crc, rc-channels type and length 24 leaves sixteen
// words on the out_ channel, one 11-bit channel each, tlast on channel 15.
// Parsing takes a byte whenever in_tready is high; in_tready is high
// whenever no frame is being unpacked. Unpacking walks the 22 payload bytes
// through the store's single read port, with a read and a load state per byte
// fetched and an emit state per channel sent, while in_tready is low. A finished word
// waits in the output register, so a stalled receiver only holds up the
// unpacker, and input resumes once the last channel has been loaded there.
// Configuration writes (cfg_index 0 gap limit, 1 device address) are taken
// at once, cfg_ready is always high. Synchronous reset returns the parser
// to the address byte, clears the frame count and last arrival time and
// loads gap limit 2000 and address 0xC8; the frame store needs no clearing.
module crsf_rc_frame_receiver
  import crsf_rx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: rx_byte [7:0], arrival_time [39:8]
  input  logic [39:0] in_tdata,
  // in_tuser: line_error
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: channel_index [3:0], channel_value [14:4], frame_time [46:15],
  // frame_number [78:47], zero [79]
  output logic [79:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  unpack_state_t          state_r, state_nxt;
  logic [31:0]            gap_limit_r;
  logic [7:0]             dev_addr_r;
  logic [STORE_AW-1:0]    pos_r, pos_nxt;
  logic [STORE_AW-1:0]    len_r, len_nxt;
  logic [7:0]             crc_r, crc_nxt;
  logic                   type_ok_r, type_ok_nxt;
  logic [31:0]            last_arrival_r;
  logic [31:0]            valid_frames_r, valid_frames_nxt;
  logic [31:0]            frame_time_r, frame_time_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [ACC_CNT_W-1:0]   acc_cnt_r, acc_cnt_nxt;
  logic [3:0]             chan_r, chan_nxt;
  logic [STORE_AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic                   out_valid_r;
  logic [79:0]            out_data_r;
  logic                   out_last_r;

  logic [7:0]             rx_byte;
  logic                   line_error;
  logic [31:0]            arrival_time;
  logic                   in_fire, byte_fire, gap_over, emit;
  logic [STORE_AW-1:0]    pos_eff;
  logic [7:0]             crc_base;
  logic                   wr_en;
  logic [7:0]             rd_data;
  logic [ACC_CNT_W-1:0]   cnt_after_emit;

  assign rx_byte      = in_tdata[7:0];
  assign arrival_time = in_tdata[39:8];
  assign line_error   = in_tuser;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign byte_fire = in_fire && !line_error;
  assign cfg_ready = 1'b1;

  assign gap_over = (arrival_time - last_arrival_r) > gap_limit_r;
  assign pos_eff  = gap_over ? '0 : pos_r;
  assign crc_base = (pos_eff == STORE_AW'(2)) ? 8'h00 : crc_r;

  assign emit           = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign cnt_after_emit = acc_cnt_r - ACC_CNT_W'(CHAN_W);

  crsf_rx_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos_eff),
    .wr_data (rx_byte),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  // byte parser and unpack sequencer
  always_comb begin
    state_nxt        = state_r;
    pos_nxt          = pos_r;
    len_nxt          = len_r;
    crc_nxt          = crc_r;
    type_ok_nxt      = type_ok_r;
    valid_frames_nxt = valid_frames_r;
    frame_time_nxt   = frame_time_r;
    acc_nxt          = acc_r;
    acc_cnt_nxt      = acc_cnt_r;
    chan_nxt         = chan_r;
    rd_addr_nxt      = rd_addr_r;
    wr_en            = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && line_error) begin
          pos_nxt = '0;
          len_nxt = '0;
        end else if (byte_fire) begin
          priority if (pos_eff == '0) begin
            if (rx_byte == dev_addr_r) begin
              wr_en   = 1'b1;
              pos_nxt = STORE_AW'(1);
            end else begin
              pos_nxt = '0;
            end
            len_nxt = '0;
          end else if (pos_eff == STORE_AW'(1)) begin
            if (rx_byte < 8'(MIN_LENGTH) || rx_byte > 8'(MAX_LENGTH)) begin
              pos_nxt = '0;
              len_nxt = '0;
            end else begin
              wr_en   = 1'b1;
              len_nxt = rx_byte[STORE_AW-1:0];
              pos_nxt = STORE_AW'(2);
            end
          end else begin
            wr_en = 1'b1;
            if (pos_eff == STORE_AW'(2)) begin
              type_ok_nxt = (rx_byte == RC_TYPE);
            end
            if (pos_eff <= len_r) begin
              crc_nxt = crc_step(crc_base, rx_byte);
              pos_nxt = pos_eff + STORE_AW'(1);
            end else begin
              // crc byte closes the frame
              pos_nxt = '0;
              len_nxt = '0;
              if (crc_r == rx_byte && type_ok_r && 8'(len_r) == RC_LENGTH) begin
                valid_frames_nxt = valid_frames_r + 32'd1;
                frame_time_nxt   = arrival_time;
                acc_nxt          = '0;
                acc_cnt_nxt      = '0;
                chan_nxt         = '0;
                rd_addr_nxt      = PAYLOAD_FIRST;
                state_nxt        = S_READ;
              end
            end
          end
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        acc_nxt     = acc_r | (ACC_W'(rd_data) << acc_cnt_r);
        acc_cnt_nxt = acc_cnt_r + ACC_CNT_W'(8);
        rd_addr_nxt = rd_addr_r + STORE_AW'(1);
        state_nxt   = (acc_cnt_nxt >= ACC_CNT_W'(CHAN_W)) ? S_EMIT : S_READ;
      end
      S_EMIT: begin
        if (emit) begin
          acc_nxt     = acc_r >> CHAN_W;
          acc_cnt_nxt = cnt_after_emit;
          chan_nxt    = chan_r + 4'd1;
          priority if (chan_r == 4'(NUM_CHANNELS - 1)) begin
            state_nxt = S_IDLE;
          end else if (cnt_after_emit >= ACC_CNT_W'(CHAN_W)) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      gap_limit_r    <= GAP_RESET;
      dev_addr_r     <= ADDR_RESET;
      pos_r          <= '0;
      len_r          <= '0;
      last_arrival_r <= '0;
      valid_frames_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      pos_r          <= pos_nxt;
      len_r          <= len_nxt;
      valid_frames_r <= valid_frames_nxt;
      if (byte_fire) begin
        last_arrival_r <= arrival_time;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_GAP_LIMIT:      gap_limit_r <= cfg_data;
          REG_DEVICE_ADDRESS: dev_addr_r  <= cfg_data[7:0];
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    crc_r        <= crc_nxt;
    type_ok_r    <= type_ok_nxt;
    frame_time_r <= frame_time_nxt;
    acc_r        <= acc_nxt;
    acc_cnt_r    <= acc_cnt_nxt;
    chan_r       <= chan_nxt;
    rd_addr_r    <= rd_addr_nxt;
    if (emit) begin
      out_data_r <= {1'b0, valid_frames_r, frame_time_r, acc_r[CHAN_W-1:0], chan_r};
      out_last_r <= (chan_r == 4'(NUM_CHANNELS - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("unpack state not one-hot");

  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> $past(state_r == S_READ))
    else $error("store data used without a read issued");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (acc_cnt_r <= ACC_CNT_W'(ACC_W)))
    else $error("bit accumulator overfilled");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && chan_r == 4'(NUM_CHANNELS - 1)) |=> (state_r == S_IDLE && acc_cnt_r == '0))
    else $error("frame unpack ended with bits left over");

  a_count_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_frames_r != $past(valid_frames_r)) |-> (state_r == S_READ && $past(in_fire)))
    else $error("frame count moved without a frame starting");

endmodule
